// ===== rtl/core/brlp_pkg.sv =====
// brlp_pkg: shared types, constants and character codes for the bit range list parser
// no dependencies; used by brlp_mask_gen, brlp_parse and bit_range_list_parser
`timescale 1ns / 1ps

package brlp_pkg;

  // width of the collected bit mask
  localparam int MASK_BITS = 32;
  // width of the result mask field on the output stream
  localparam int OUT_MASK_W = 32;
  // width of the number accumulator: holds 0 .. MASK_BITS-1
  localparam int NUM_W = $clog2(MASK_BITS);
  // width of accumulator * 10 + digit
  localparam int VAL_W = NUM_W + 4;
  // width of the character field
  localparam int CH_W = 8;

  // character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

  // parser phase
  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_FIRST       = 3'd1,
    PH_AFTER_COMMA = 3'd2,
    PH_DASH        = 3'd3,
    PH_SECOND      = 3'd4
  } phase_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_INT   = 3'd1,
    ERR_RANGE = 3'd2,
    ERR_OP    = 3'd3,
    ERR_BIG   = 3'd4
  } err_t;

  // one result item
  typedef struct packed {
    logic [MASK_BITS-1:0] mask;
    err_t                 error;
    logic                 done;
  } result_t;

endpackage

// ===== rtl/core/brlp_mask_gen.sv =====
// brlp_mask_gen: forms the bits to set for a single number or for a range lo+1 .. hi
// depends on brlp_pkg
`timescale 1ns / 1ps

module brlp_mask_gen (
  input  logic                          range_sel, // 1: bits lo+1..hi, 0: bit hi only
  input  logic [brlp_pkg::NUM_W-1:0]    lo,
  input  logic [brlp_pkg::NUM_W-1:0]    hi,
  output logic [brlp_pkg::MASK_BITS-1:0] bits
);

  // one compare pair per bit position
  always_comb begin
    for (int i = 0; i < brlp_pkg::MASK_BITS; i++) begin
      if (range_sel) begin
        bits[i] = (lo < brlp_pkg::NUM_W'(i)) && (brlp_pkg::NUM_W'(i) <= hi);
      end else begin
        bits[i] = (brlp_pkg::NUM_W'(i) == hi);
      end
    end
  end

endmodule

// ===== rtl/core/brlp_parse.sv =====
// brlp_parse: parser state registers and the per-item next-state and result logic
// depends on brlp_pkg and brlp_mask_gen
`timescale 1ns / 1ps

module brlp_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,     // process the held item this cycle
  input  logic                       last,     // end of parameter
  input  logic [brlp_pkg::CH_W-1:0]  ch,
  output brlp_pkg::result_t          res_next
);

  brlp_pkg::phase_t                 phase, phase_next;
  logic [brlp_pkg::NUM_W-1:0]       acc, acc_next;
  logic [brlp_pkg::NUM_W-1:0]       range_start, range_start_next;
  logic [brlp_pkg::MASK_BITS-1:0]   mask, mask_next;
  brlp_pkg::err_t                   err, err_next;
  logic                             done;

  logic                             is_space, is_digit, active;
  logic [3:0]                       digit;
  logic [brlp_pkg::VAL_W-1:0]       val_cont, val_first;
  logic                             big_cont, big_first;
  logic                             mg_range;
  logic [brlp_pkg::MASK_BITS-1:0]   mg_bits;

  // character classes and digit arithmetic
  always_comb begin
    is_space  = (ch == brlp_pkg::CH_SPACE) ||
                ((ch >= brlp_pkg::CH_TAB) && (ch <= brlp_pkg::CH_CR));
    is_digit  = (ch >= brlp_pkg::CH_ZERO) && (ch <= brlp_pkg::CH_NINE);
    digit     = 4'(ch - brlp_pkg::CH_ZERO);
    val_cont  = (brlp_pkg::VAL_W'(acc) << 3) + (brlp_pkg::VAL_W'(acc) << 1)
                + brlp_pkg::VAL_W'(digit);
    val_first = brlp_pkg::VAL_W'(digit);
    big_cont  = val_cont > brlp_pkg::VAL_W'(brlp_pkg::MASK_BITS - 1);
    big_first = val_first > brlp_pkg::VAL_W'(brlp_pkg::MASK_BITS - 1);
    active    = (err == brlp_pkg::ERR_NONE) && (last || !is_space);
  end

  // bits of the finished number or range
  assign mg_range = (phase == brlp_pkg::PH_SECOND);

  brlp_mask_gen u_mask_gen (
    .range_sel (mg_range),
    .lo        (range_start),
    .hi        (acc),
    .bits      (mg_bits)
  );

  // next state
  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    range_start_next = range_start;
    mask_next        = mask;
    err_next         = err;
    done             = 1'b0;
    if (active) begin
      unique case (phase)
        brlp_pkg::PH_START, brlp_pkg::PH_AFTER_COMMA, brlp_pkg::PH_DASH: begin
          if (phase == brlp_pkg::PH_START && last) begin
            done = 1'b1;
          end else if (!last && is_digit) begin
            if (big_first) begin
              err_next = brlp_pkg::ERR_BIG;
            end else begin
              acc_next   = brlp_pkg::NUM_W'(val_first);
              phase_next = (phase == brlp_pkg::PH_DASH) ? brlp_pkg::PH_SECOND
                                                        : brlp_pkg::PH_FIRST;
            end
          end else begin
            err_next = brlp_pkg::ERR_INT;
          end
        end
        brlp_pkg::PH_FIRST, brlp_pkg::PH_SECOND: begin
          if (!last && is_digit) begin
            if (big_cont) begin
              err_next = brlp_pkg::ERR_BIG;
            end else begin
              acc_next = brlp_pkg::NUM_W'(val_cont);
            end
          end else if (phase == brlp_pkg::PH_SECOND && acc <= range_start) begin
            err_next = brlp_pkg::ERR_RANGE;
          end else begin
            mask_next = mask | mg_bits;
            if (phase == brlp_pkg::PH_FIRST) begin
              range_start_next = acc;
            end
            // what follows a finished number or range
            if (last) begin
              phase_next = brlp_pkg::PH_START;
              acc_next   = '0;
              done       = 1'b1;
            end else if (ch == brlp_pkg::CH_COMMA) begin
              phase_next = brlp_pkg::PH_AFTER_COMMA;
            end else if (phase == brlp_pkg::PH_FIRST && ch == brlp_pkg::CH_DASH) begin
              phase_next = brlp_pkg::PH_DASH;
            end else begin
              err_next = brlp_pkg::ERR_OP;
            end
          end
        end
        default: begin
          phase_next = brlp_pkg::PH_START;
        end
      endcase
    end
  end

  // result of this item
  always_comb begin
    res_next.mask  = mask_next;
    res_next.error = err_next;
    res_next.done  = done && (err_next == brlp_pkg::ERR_NONE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= brlp_pkg::PH_START;
      acc         <= '0;
      range_start <= '0;
      mask        <= '0;
      err         <= brlp_pkg::ERR_NONE;
    end else if (step) begin
      phase       <= phase_next;
      acc         <= acc_next;
      range_start <= range_start_next;
      mask        <= mask_next;
      err         <= err_next;
    end
  end

  // an error, once raised, freezes the error code and the mask
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != brlp_pkg::ERR_NONE) |=> (err == $past(err)) && (mask == $past(mask)))
    else $error("error code or mask changed after an error");

  // bits are only ever added to the mask
  a_mask_grows: assert property (@(posedge clk) disable iff (rst)
    step |=> ((mask & $past(mask)) == $past(mask)))
    else $error("mask lost a bit");

  // accumulator never leaves the mask range
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (phase == brlp_pkg::PH_FIRST || phase == brlp_pkg::PH_SECOND)
      |-> (32'(acc) < 32'(brlp_pkg::MASK_BITS)))
    else $error("accumulator out of range");

endmodule

// ===== rtl/core/bit_range_list_parser.sv =====
// bit_range_list_parser: stream wrapper with input register and result register
// depends on brlp_pkg and brlp_parse
`timescale 1ns / 1ps
// result path: an input transfer is held in the input register, and its result is loaded
//   into the result register when the item advances, so a stalled output delays it
// throughput: one item per cycle unless the output stalls; the input register feeds
//   the parser step and the result register in the same cycle, so items flow without gaps
// reset: rst clears the parser to its start phase, empties the mask and the error
//   code, and drops both stage valid flags

module bit_range_list_parser (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] ch
  input  logic                               s_axis_tlast,  // operation: end of parameter
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [brlp_pkg::OUT_MASK_W-1:0]    m_axis_tdata,  // [31:0] mask
  output logic [2:0]                         m_axis_tuser,  // [2:0] error
  output logic                               m_axis_tlast   // parameter_done
);

  logic                          in_valid;
  logic [brlp_pkg::CH_W-1:0]     in_ch;
  logic                          in_last;
  logic                          advance;
  brlp_pkg::result_t             res_next, res;
  logic                          out_valid;

  // the held item moves on when the result register is free or being drained
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch   <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // parser
  brlp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .last     (in_last),
    .ch       (in_ch),
    .res_next (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  // output stream
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = brlp_pkg::OUT_MASK_W'(res.mask);
  assign m_axis_tuser  = res.error;
  assign m_axis_tlast  = res.done;

  // a held item waiting on a stalled output is not dropped
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("held input item lost");

  // a closed parameter never carries an error
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.done) |-> (res.error == brlp_pkg::ERR_NONE))
    else $error("parameter closed with an error");

  // the result register is loaded only when its old content is gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (advance && out_valid) |-> m_axis_tready)
    else $error("result overwritten before transfer");

endmodule
